FILE: sv/source_keyword_lexer_core_macros.svh
// Assertion helpers used by the lexer core module.
`ifndef SOURCE_KEYWORD_LEXER_CORE_MACROS_SVH
`define SOURCE_KEYWORD_LEXER_CORE_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define SKL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SKL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/skl_pkg.sv
package skl_pkg;

    localparam int unsigned KindBits  = 6;
    localparam int unsigned LenBits   = 18;
    localparam int unsigned ValueBits = 64;

    localparam logic [KindBits-1:0] KIND_NUMBER = 6'd50;
    localparam logic [KindBits-1:0] KIND_STRING = 6'd51;
    localparam logic [KindBits-1:0] KIND_NAME   = 6'd52;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_COMMENT = 3'd1,
        M_STRING  = 3'd2,
        M_MINUS   = 3'd3,
        M_NUMBER  = 3'd4,
        M_WORD    = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        P_FIRST  = 3'd0,
        P_ZERO   = 3'd1,
        P_HEXPFX = 3'd2,
        P_DEC    = 3'd3,
        P_OCT    = 3'd4,
        P_HEX    = 3'd5,
        P_DONE   = 3'd6
    } phase_t;

    // Request from the scanner to the number unit for the current byte.
    typedef struct packed {
        logic       start;     // clear the accumulator before this byte
        logic       negative;  // sign for a fresh number
        logic       feed;      // byte belongs to the number
    } num_ctl_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || is_alpha(c);
    endfunction

    // Keyword lookup for words of at most eight characters, held left-aligned
    // with the first character in the top byte.
    function automatic logic [KindBits-1:0] keyword_code(input logic [63:0] w,
                                                         input logic [3:0] len);
        logic [KindBits-1:0] k;
        k = KIND_NAME;
        case (len)
            4'd1: if (w[63:56] == "a") k = 6'd17;
            4'd2:
            begin
                case (w[63:48])
                    "if": k = 6'd14;
                    "an": k = 6'd17;
                    "at": k = 6'd21;
                    "it": k = 6'd22;
                    default: k = KIND_NAME;
                endcase
            end
            4'd3:
            begin
                case (w[63:40])
                    "add": k = 6'd2;
                    "end": k = 6'd16;
                    "the": k = 6'd59;
                    default: k = KIND_NAME;
                endcase
            end
            4'd4:
            begin
                case (w[63:32])
                    "load": k = 6'd7;
                    "move": k = 6'd8;
                    "less": k = 6'd11;
                    "else": k = 6'd14;
                    "into": k = 6'd19;
                    "from": k = 6'd20;
                    "that": k = 6'd22;
                    "with": k = 6'd24;
                    "call": k = 6'd25;
                    "halt": k = 6'd31;
                    "exit": k = 6'd31;
                    "byte": k = 6'd53;
                    "long": k = 6'd54;
                    "char": k = 6'd58;
                    default: k = KIND_NAME;
                endcase
            end
            4'd5:
            begin
                case (w[63:24])
                    "store": k = 6'd6;
                    "equal": k = 6'd10;
                    "print": k = 6'd13;
                    "while": k = 6'd15;
                    "bitor": k = 6'd28;
                    "shift": k = 6'd30;
                    "short": k = 6'd56;
                    default: k = KIND_NAME;
                endcase
            end
            4'd6:
            begin
                case (w[63:16])
                    "return": k = 6'd1;
                    "divide": k = 6'd5;
                    "define": k = 6'd23;
                    "bitand": k = 6'd27;
                    "bitxor": k = 6'd29;
                    "global": k = 6'd59;
                    default: k = KIND_NAME;
                endcase
            end
            4'd7:
            begin
                case (w[63:8])
                    "compare": k = 6'd9;
                    "greater": k = 6'd12;
                    "syscall": k = 6'd26;
                    "integer": k = 6'd55;
                    "boolean": k = 6'd57;
                    default: k = KIND_NAME;
                endcase
            end
            4'd8:
            begin
                case (w)
                    "subtract": k = 6'd3;
                    "multiply": k = 6'd4;
                    default: k = KIND_NAME;
                endcase
            end
            default: k = KIND_NAME;
        endcase
        return k;
    endfunction

endpackage

FILE: sv/source_keyword_lexer_core.sv
// Streaming keyword lexer.
// Input channel: in_valid/in_stall with func (1 = end of input) and char_in.
// Output channel: out_valid/out_stall with token_kind, token_start,
// token_length and token_value; one token at most per input item.
// Each item is handled in one pass from the state registers into the output
// register, so a token appears on the output in the cycle after the item that
// ends it is accepted. One item is taken per cycle when the output is free.
// The output register holds one token; while it is full and stalled, input
// stall is raised, and it drops in the same cycle the token is taken, so
// back-to-back flow continues under a receiver that never stalls.
// Reset clears the scanner to idle at position zero and empties the output.
// End of input flushes the pending token and restarts at position zero.
// Bytes from the all-ones position on are dropped until end of input.
// The word buffer keeps WORD_BUFFER_CHARS bytes; longer words are names.
module source_keyword_lexer_core
    import skl_pkg::*;
#(
    parameter int unsigned POSITION_BITS     = 18,
    parameter int unsigned WORD_BUFFER_CHARS = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [7:0]                  char_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [KindBits-1:0]         token_kind,
    output logic [LenBits-1:0]          token_start,
    output logic [LenBits-1:0]          token_length,
    output logic signed [ValueBits-1:0] token_value
);

`include "source_keyword_lexer_core_macros.svh"

    localparam int unsigned IdxBits = $clog2(WORD_BUFFER_CHARS);
    localparam logic [POSITION_BITS-1:0] PosMax = '1;

    mode_t                  mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic                   overlong_reg, overlong_next;
    logic [7:0]             wbuf_reg [WORD_BUFFER_CHARS];
    logic                   out_valid_reg;
    logic [KindBits-1:0]    kind_reg;
    logic [LenBits-1:0]     start_out_reg;
    logic [LenBits-1:0]     len_out_reg;
    logic [ValueBits-1:0]   value_reg;

    logic                   step;
    logic                   emit;
    logic [KindBits-1:0]    emit_kind;
    logic                   again;
    logic                   wr_en;
    logic [POSITION_BITS-1:0] wr_off;
    logic [POSITION_BITS-1:0] cur_len;
    num_ctl_t               nctl;
    logic [ValueBits-1:0]   num_value;
    logic [63:0]            word8;
    logic [KindBits-1:0]    word_kind;

    assign in_stall = out_valid_reg && out_stall;
    assign step = in_valid && !in_stall;
    assign cur_len = pos_reg - start_reg;

    always_comb
    begin
        word8 = '0;
        for (int i = 0; i < 8; i++)
            if (i < WORD_BUFFER_CHARS)
                word8[63 - 8*i -: 8] = wbuf_reg[i];
        if (overlong_reg || (cur_len > POSITION_BITS'(WORD_BUFFER_CHARS)) ||
            (cur_len > POSITION_BITS'(8)))
            word_kind = KIND_NAME;
        else
            word_kind = keyword_code(word8, cur_len[3:0]);
    end

    always_comb
    begin
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        overlong_next = overlong_reg;
        emit          = 1'b0;
        emit_kind     = KIND_NAME;
        again         = 1'b0;
        wr_en         = 1'b0;
        wr_off        = '0;
        nctl          = '0;
        if (func)
        begin
            case (mode_reg)
                M_STRING: begin emit = 1'b1; emit_kind = KIND_STRING; end
                M_NUMBER: begin emit = 1'b1; emit_kind = KIND_NUMBER; end
                M_WORD:   begin emit = 1'b1; emit_kind = word_kind;   end
                default:  emit = 1'b0;
            endcase
            mode_next     = M_IDLE;
            pos_next      = '0;
            start_next    = '0;
            overlong_next = 1'b0;
        end
        else if (pos_reg != PosMax)
        begin
            case (mode_reg)
                M_COMMENT: if (char_in == 8'h0a) mode_next = M_IDLE;
                M_STRING:
                begin
                    if (char_in == 8'h22)
                    begin
                        emit = 1'b1;
                        emit_kind = KIND_STRING;
                        mode_next = M_IDLE;
                    end
                end
                M_MINUS:
                begin
                    if (is_digit(char_in))
                    begin
                        mode_next = M_NUMBER;
                        nctl = '{start: 1'b1, negative: 1'b1, feed: 1'b1};
                    end
                    else
                        again = 1'b1;
                end
                M_NUMBER:
                begin
                    if (is_alnum(char_in))
                        nctl.feed = 1'b1;
                    else
                    begin
                        emit = 1'b1;
                        emit_kind = KIND_NUMBER;
                        again = 1'b1;
                    end
                end
                M_WORD:
                begin
                    if (is_alnum(char_in) || (char_in == 8'h5f))
                    begin
                        wr_en = 1'b1;
                        wr_off = cur_len;
                    end
                    else
                    begin
                        emit = 1'b1;
                        emit_kind = word_kind;
                        again = 1'b1;
                    end
                end
                default: again = 1'b1;
            endcase
            if (again)
            begin
                mode_next = M_IDLE;
                if (char_in == 8'h23)
                    mode_next = M_COMMENT;
                else if (char_in == 8'h22)
                begin
                    mode_next = M_STRING;
                    start_next = pos_reg + 1'b1;
                end
                else if (char_in == 8'h2d)
                begin
                    mode_next = M_MINUS;
                    start_next = pos_reg;
                end
                else if (is_digit(char_in))
                begin
                    mode_next = M_NUMBER;
                    start_next = pos_reg;
                    nctl = '{start: 1'b1, negative: 1'b0, feed: 1'b1};
                end
                else if (is_alpha(char_in) || (char_in == 8'h5f))
                begin
                    mode_next = M_WORD;
                    start_next = pos_reg;
                    overlong_next = 1'b0;
                    wr_en = 1'b1;
                    wr_off = '0;
                end
            end
            if (wr_en && (wr_off >= POSITION_BITS'(WORD_BUFFER_CHARS)))
            begin
                wr_en = 1'b0;
                overlong_next = 1'b1;
            end
            pos_next = pos_reg + 1'b1;
        end
    end

    skl_number u_number (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step && !func && (pos_reg != PosMax)),
        .ctl     (nctl),
        .char_in (char_in),
        .value   (num_value)
    );

    always_ff @(posedge clk)
    begin
        if (step && wr_en)
            wbuf_reg[wr_off[IdxBits-1:0]] <= char_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            pos_reg       <= '0;
            start_reg     <= '0;
            overlong_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step && emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (step)
            begin
                mode_reg     <= mode_next;
                pos_reg      <= pos_next;
                start_reg    <= start_next;
                overlong_reg <= overlong_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            kind_reg      <= emit_kind;
            start_out_reg <= LenBits'(start_reg);
            len_out_reg   <= LenBits'(cur_len);
            value_reg     <= (emit_kind == KIND_NUMBER) ? num_value : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = kind_reg;
    assign token_start  = start_out_reg;
    assign token_length = len_out_reg;
    assign token_value  = value_reg;

    `SKL_ASSERT_NEXT(a_end_resets_pos, clk, rst_n, step && func, pos_reg == '0,
        "position not cleared after end of input")
    `SKL_ASSERT_NEXT(a_emit_shows, clk, rst_n, step && emit, out_valid,
        "token not presented after emit")
    `SKL_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_valid && out_stall, !step,
        "item accepted while output is held")
    `SKL_ASSERT_IMPL(a_start_le_pos, clk, rst_n, mode_reg == M_WORD || mode_reg == M_NUMBER,
        start_reg <= pos_reg, "token start beyond current position")

endmodule

FILE: sv/skl_number.sv
module skl_number
    import skl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  num_ctl_t             ctl,
    input  logic [7:0]           char_in,
    output logic [ValueBits-1:0] value
);

    localparam logic [63:0] PosLimit = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] NegLimit = 64'h8000_0000_0000_0000;

    phase_t      phase_reg, phase_next;
    logic [63:0] accum_reg, accum_next;
    logic        neg_reg, neg_next;
    logic        ovf_reg, ovf_next;

    phase_t      ph;
    logic [63:0] acc;
    logic        neg;
    logic        ovf;
    logic        take;
    logic [1:0]  base_sel;  // 0 decimal, 1 octal, 2 hex
    logic [3:0]  digit;
    logic [63:0] limit;
    logic [67:0] prod;
    logic [67:0] sum;
    logic [3:0]  hexv;
    logic        hexok;

    always_comb
    begin
        hexok = 1'b1;
        hexv  = 4'd0;
        if (is_digit(char_in))
            hexv = 4'(char_in - 8'h30);
        else if ((char_in >= 8'h61) && (char_in <= 8'h66))
            hexv = 4'(char_in - 8'h57);
        else if ((char_in >= 8'h41) && (char_in <= 8'h46))
            hexv = 4'(char_in - 8'h37);
        else
            hexok = 1'b0;
    end

    always_comb
    begin
        ph  = ctl.start ? P_FIRST : phase_reg;
        acc = ctl.start ? 64'd0 : accum_reg;
        neg = ctl.start ? ctl.negative : neg_reg;
        ovf = ctl.start ? 1'b0 : ovf_reg;
        take     = 1'b0;
        base_sel = 2'd0;
        digit    = 4'(char_in - 8'h30);
        phase_next = ph;
        case (ph)
            P_FIRST:
            begin
                if (char_in == 8'h30)
                    phase_next = P_ZERO;
                else
                begin
                    phase_next = P_DEC;
                    take = 1'b1;
                end
            end
            P_ZERO:
            begin
                if ((char_in == 8'h78) || (char_in == 8'h58))
                    phase_next = P_HEXPFX;
                else if ((char_in >= 8'h30) && (char_in <= 8'h37))
                begin
                    phase_next = P_OCT;
                    take = 1'b1;
                    base_sel = 2'd1;
                end
                else
                    phase_next = P_DONE;
            end
            P_HEXPFX, P_HEX:
            begin
                base_sel = 2'd2;
                digit = hexv;
                if (hexok)
                begin
                    phase_next = P_HEX;
                    take = 1'b1;
                end
                else
                    phase_next = P_DONE;
            end
            P_DEC:
            begin
                if (is_digit(char_in))
                    take = 1'b1;
                else
                    phase_next = P_DONE;
            end
            P_OCT:
            begin
                base_sel = 2'd1;
                if ((char_in >= 8'h30) && (char_in <= 8'h37))
                    take = 1'b1;
                else
                    phase_next = P_DONE;
            end
            default: phase_next = P_DONE;
        endcase

        // acc*base+d exceeds the limit exactly when the wide sum does.
        limit = neg ? NegLimit : PosLimit;
        case (base_sel)
            2'd1:    prod = {acc, 3'b000} + 68'd0;
            2'd2:    prod = {acc, 4'b0000};
            default: prod = {acc, 3'b000} + {3'b000, acc, 1'b0};
        endcase
        sum = prod + {64'd0, digit};
        accum_next = acc;
        ovf_next   = ovf;
        if (take && !ovf)
        begin
            if (sum > {4'd0, limit})
                ovf_next = 1'b1;
            else
                accum_next = sum[63:0];
        end
        neg_next = neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_FIRST;
            accum_reg <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (step && ctl.feed)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        if (ovf_reg)
            value = neg_reg ? NegLimit : PosLimit;
        else
            value = neg_reg ? (64'd0 - accum_reg) : accum_reg;
    end

endmodule
